/* hdl/crc32wb_pkg.sv */
// Shared constants and types for the CRC-32 word engine.
package crc32wb_pkg;

	// Largest item that takes the Barrett word path, in bytes.
	localparam int WORD_BYTES = 8;

	// Bits of the variant register.
	localparam int VARIANT_W      = 2;
	localparam int VAR_BIT_CASTAG = 0;   // selects the CRC-32C polynomial on the reflected path
	localparam int VAR_BIT_NORMAL = 1;   // selects the normal MSB-first path

	// Configuration register indexes.
	localparam logic CFG_IDX_VARIANT = 1'b0;
	localparam logic CFG_IDX_SEED    = 1'b1;

	// Barrett quotient constants.
	localparam logic [63:0] QT_LE_CRC32  = 64'h5a72_d812_fb80_8b20;
	localparam logic [63:0] QT_LE_CRC32C = 64'ha434_f61c_6f53_89f8;
	localparam logic [63:0] QT_BE_CRC32  = 64'h04d1_01df_481b_4e5a;

	// Generator polynomials.
	localparam logic [31:0] POLY_LE_CRC32  = 32'hedb8_8320;
	localparam logic [31:0] POLY_LE_CRC32C = 32'h82f6_3b78;
	localparam logic [31:0] POLY_BE_CRC32  = 32'h04c1_1db7;

	// Controls handed to the byte folding unit.
	typedef struct packed {
		logic        normal;
		logic [31:0] poly_le;
	} fold_ctrl_t;

endpackage

/* hdl/crc32_word_barrett_core.sv */
// Top level of the CRC-32 word engine: stream ports, configuration and sequencer.
// A full eight-byte item makes four passes through the shared 32x32 carry-less multiplier,
// then its result moves into the output register; a partial item of n bytes is first
// folded at one byte fold per cycle. The input is ready again only once the result has
// moved to the output register, which waits while it is full, so one item is taken at a time.
// Reset (arst_n low, asynchronous) clears the remainder, variant and seed registers to zero.
module crc32_word_barrett_core #(
	parameter int WORD_BYTES = crc32wb_pkg::WORD_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // [63:0] data_bytes, [67:64] byte_count, [71:68] zero
	input  logic        s_axis_tuser,   // [0] first
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [31:0] crc_value
);

	// One-hot sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WORD = 4'b0010,
		ST_BYTE = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [crc32wb_pkg::VARIANT_W-1:0] variant_q;
	logic [31:0] seed_q;

	// The running remainder. It is also the working remainder while an item is folded,
	// since only one item is ever in flight.
	logic [31:0] crc_q;

	// Holds the Barrett operand s during a word, or the remaining bytes during a partial item.
	logic [63:0] work_q;
	// Partial product accumulator for the first carry-less multiply.
	logic [63:0] acc_q;
	logic [1:0]  step_q;
	logic [3:0]  rem_q;

	logic        out_valid_q;
	logic [31:0] out_data_q;

	// Decoded input fields.
	logic [63:0] in_data;
	logic [3:0]  in_count;
	logic [3:0]  count_c;
	logic        in_first;
	logic        in_fire;
	logic        word_go;
	logic [31:0] crc_start;
	logic [63:0] data_swapped;
	logic [63:0] s_start;

	// Variant decode.
	logic        normal;
	logic [31:0] poly_le;
	logic [63:0] qt_le;

	// Shared multiplier operands and product.
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [62:0] mul_p;
	logic [63:0] t_word;

	logic [31:0] fold_out;
	crc32wb_pkg::fold_ctrl_t fold_ctrl;

	logic emit_fire;

	assign in_data  = s_axis_tdata[63:0];
	assign in_count = s_axis_tdata[67:64];
	assign in_first = s_axis_tuser;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Counts above eight saturate to a full word.
	assign count_c = (in_count > 4'd8) ? 4'd8 : in_count;
	assign word_go = (WORD_BYTES == 8) && (count_c == 4'd8);

	assign normal  = variant_q[crc32wb_pkg::VAR_BIT_NORMAL];
	assign poly_le = variant_q[crc32wb_pkg::VAR_BIT_CASTAG] ? crc32wb_pkg::POLY_LE_CRC32C
	                                                        : crc32wb_pkg::POLY_LE_CRC32;
	assign qt_le   = variant_q[crc32wb_pkg::VAR_BIT_CASTAG] ? crc32wb_pkg::QT_LE_CRC32C
	                                                        : crc32wb_pkg::QT_LE_CRC32;

	assign crc_start = in_first ? seed_q : crc_q;

	// The normal path takes the message bytes most significant first.
	always_comb begin
		data_swapped = '0;
		for (int i = 0; i < 8; i++) begin
			data_swapped[8*(7-i) +: 8] = in_data[8*i +: 8];
		end
	end

	// On a word, work_q is loaded with the Barrett operand s; otherwise with the raw bytes.
	always_comb begin
		if (!word_go) begin
			s_start = in_data;
		end else if (normal) begin
			s_start = {crc_start, 32'b0} ^ data_swapped;
		end else begin
			s_start = {32'b0, crc_start} ^ in_data;
		end
	end

	// The quotient estimate t is formed from the accumulated low or high product half and s.
	assign t_word = normal ? (acc_q ^ work_q) : ({acc_q[62:0], 1'b0} ^ work_q);

	// Operand schedule. The reflected path needs the low half of s * qt, built from three
	// partial products, then t_hi * poly. The normal path needs the high half of s * qt,
	// again three partial products, then t_lo * poly.
	always_comb begin
		mul_a = work_q[31:0];
		mul_b = qt_le[31:0];
		if (normal) begin
			unique case (step_q)
				2'd0: begin
					mul_a = work_q[63:32];
					mul_b = crc32wb_pkg::QT_BE_CRC32[63:32];
				end
				2'd1: begin
					mul_a = work_q[63:32];
					mul_b = crc32wb_pkg::QT_BE_CRC32[31:0];
				end
				2'd2: begin
					mul_a = work_q[31:0];
					mul_b = crc32wb_pkg::QT_BE_CRC32[63:32];
				end
				default: begin
					mul_a = t_word[31:0];
					mul_b = crc32wb_pkg::POLY_BE_CRC32;
				end
			endcase
		end else begin
			unique case (step_q)
				2'd0: begin
					mul_a = work_q[31:0];
					mul_b = qt_le[31:0];
				end
				2'd1: begin
					mul_a = work_q[31:0];
					mul_b = qt_le[63:32];
				end
				2'd2: begin
					mul_a = work_q[63:32];
					mul_b = qt_le[31:0];
				end
				default: begin
					mul_a = t_word[63:32];
					mul_b = poly_le;
				end
			endcase
		end
	end

	crc32wb_clmul u_clmul (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	assign fold_ctrl.normal  = normal;
	assign fold_ctrl.poly_le = poly_le;

	crc32wb_byte_fold u_byte_fold (
		.ctrl      (fold_ctrl),
		.crc_in    (crc_q),
		.data_byte (work_q[7:0]),
		.crc_out   (fold_out)
	);

	// A result leaves the EMIT state once the output register is free or being drained.
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

	// Sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (word_go) begin
						state_d = ST_WORD;
					end else if (count_c != 4'd0) begin
						state_d = ST_BYTE;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_WORD: begin
				if (step_q == 2'd3) begin
					state_d = ST_EMIT;
				end
			end
			ST_BYTE: begin
				if (rem_q == 4'd1) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= '0;
			seed_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				crc32wb_pkg::CFG_IDX_VARIANT: variant_q <= cfg_wdata[crc32wb_pkg::VARIANT_W-1:0];
				crc32wb_pkg::CFG_IDX_SEED:    seed_q    <= cfg_wdata;
				default:                      seed_q    <= seed_q;
			endcase
		end
	end

	// Running remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (in_fire) begin
			crc_q <= crc_start;
		end else if ((state_q == ST_WORD) && (step_q == 2'd3)) begin
			crc_q <= normal ? mul_p[31:0] : mul_p[62:31];
		end else if (state_q == ST_BYTE) begin
			crc_q <= fold_out;
		end
	end

	// Step and byte counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			rem_q  <= '0;
		end else if (in_fire) begin
			step_q <= '0;
			rem_q  <= count_c;
		end else if (state_q == ST_WORD) begin
			step_q <= step_q + 2'd1;
		end else if (state_q == ST_BYTE) begin
			rem_q <= rem_q - 4'd1;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			work_q <= s_start;
		end else if (state_q == ST_BYTE) begin
			work_q <= {8'b0, work_q[63:8]};
		end
		if (state_q == ST_WORD) begin
			if (step_q == 2'd0) begin
				acc_q <= {1'b0, mul_p};
			end else if (normal) begin
				acc_q <= acc_q ^ {33'b0, mul_p[62:32]};
			end else begin
				acc_q <= acc_q ^ {mul_p[31:0], 32'b0};
			end
		end
	end

	// Output register: holds a finished result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_data_q <= crc_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* hdl/crc32wb_clmul.sv */
// Shared 32x32 carry-less multiplier with a 63-bit product.
module crc32wb_clmul (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [62:0] p
);

	always_comb begin
		logic [62:0] sum;
		sum = '0;
		for (int i = 0; i < 32; i++) begin
			sum = sum ^ (({31'b0, a} << i) & {63{b[i]}});
		end
		p = sum;
	end

endmodule

/* hdl/crc32wb_byte_fold.sv */
// Folds one message byte into the CRC remainder, bit by bit.
module crc32wb_byte_fold (
	input  crc32wb_pkg::fold_ctrl_t ctrl,
	input  logic [31:0]             crc_in,
	input  logic [7:0]              data_byte,
	output logic [31:0]             crc_out
);

	always_comb begin
		logic [31:0] c;
		if (ctrl.normal) begin
			c = crc_in ^ {data_byte, 24'b0};
			for (int k = 0; k < 8; k++) begin
				c = {c[30:0], 1'b0} ^ (c[31] ? crc32wb_pkg::POLY_BE_CRC32 : 32'b0);
			end
		end else begin
			c = crc_in ^ {24'b0, data_byte};
			for (int k = 0; k < 8; k++) begin
				c = {1'b0, c[31:1]} ^ (c[0] ? ctrl.poly_le : 32'b0);
			end
		end
		crc_out = c;
	end

endmodule

/* tb/crc32_word_barrett_core_test.sv */
// Self-checking stream testbench for the CRC-32 word engine with an in-line remainder predictor.
module crc32_word_barrett_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	// One input transaction as the sender sees it.
	typedef struct packed {
		logic        first;
		logic [3:0]  count;
		logic [63:0] data;
	} crc_item_t;

	// A transaction stalled this long with nothing moving on either side means a hang.
	localparam int STALL_LIMIT   = 4000;
	// The receiver stops taking results once, for this many cycles, after this many results.
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_AT       = 1000;
	localparam int PHASE_ITEMS   = 175;
	localparam int PHASE_COUNT   = 10;
	localparam int TAIL_CYCLES   = 24;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = crc32wb_pkg::CFG_IDX_VARIANT;
	logic [31:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	crc32_word_barrett_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copies of the configuration registers and of the running remainder.
	logic [crc32wb_pkg::VARIANT_W-1:0] variant_shadow = '0;
	logic [31:0]                       seed_shadow = '0;
	logic [31:0]                       remainder_model = '0;

	crc_item_t   pending_items[$];
	logic [31:0] crc_expect_q[$];
	crc_item_t   next_item;
	int          outstanding = 0;
	int          mismatches = 0;
	int          results_seen = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	bit          gaps_on = 1'b1;

	// ---------------------------------------------------------------------------------------
	// Remainder predictor. The word path goes through Barrett reduction with the package's
	// quotient constants; everything else is folded one byte at a time, bit serially.
	// ---------------------------------------------------------------------------------------

	// Full 64x64 carry-less product.
	function automatic logic [127:0] clmul64(logic [63:0] a, logic [63:0] b);
		logic [127:0] prod;
		prod = '0;
		for (int i = 0; i < 64; i++) begin
			if (b[i]) begin
				prod ^= {64'b0, a} << i;
			end
		end
		return prod;
	endfunction

	function automatic logic [31:0] fold_byte_reflected(logic [31:0] crc, logic [7:0] b,
			logic [31:0] poly);
		crc ^= {24'b0, b};
		for (int k = 0; k < 8; k++) begin
			crc = (crc >> 1) ^ (crc[0] ? poly : 32'b0);
		end
		return crc;
	endfunction

	function automatic logic [31:0] fold_byte_normal(logic [31:0] crc, logic [7:0] b);
		crc ^= {b, 24'b0};
		for (int k = 0; k < 8; k++) begin
			crc = (crc << 1) ^ (crc[31] ? crc32wb_pkg::POLY_BE_CRC32 : 32'b0);
		end
		return crc;
	endfunction

	// Reflected word fold: the remainder lands in bits 126 down to 95 of the second product.
	function automatic logic [31:0] fold_word_reflected(logic [31:0] crc, logic [63:0] data,
			logic [31:0] poly, logic [63:0] quot);
		logic [63:0]  s;
		logic [63:0]  t;
		logic [127:0] prod;
		s    = {32'b0, crc} ^ data;
		prod = clmul64(s, quot);
		t    = (prod[63:0] << 1) ^ s;
		prod = clmul64(t, {poly, 32'b0});
		return prod[126:95];
	endfunction

	// Normal word fold: the message bytes are taken most significant first.
	function automatic logic [31:0] fold_word_normal(logic [31:0] crc, logic [63:0] data);
		logic [63:0]  s;
		logic [63:0]  swapped;
		logic [127:0] prod;
		for (int i = 0; i < 8; i++) begin
			swapped[8*(7-i) +: 8] = data[8*i +: 8];
		end
		s    = {crc, 32'b0} ^ swapped;
		prod = clmul64(s, crc32wb_pkg::QT_BE_CRC32);
		prod = clmul64(prod[127:64] ^ s, {32'b0, crc32wb_pkg::POLY_BE_CRC32});
		return prod[31:0];
	endfunction

	// Remainder after one transaction, given the remainder before it.
	function automatic logic [31:0] fold_item(logic [31:0] prev, logic [63:0] data,
			logic [3:0] count, logic first);
		logic        normal;
		logic [31:0] poly;
		logic [63:0] quot;
		logic [3:0]  nbytes;
		logic [31:0] crc;
		// Variant three behaves as the normal path since only the top bit picks it.
		normal = variant_shadow[crc32wb_pkg::VAR_BIT_NORMAL];
		poly   = variant_shadow[crc32wb_pkg::VAR_BIT_CASTAG] ? crc32wb_pkg::POLY_LE_CRC32C
			: crc32wb_pkg::POLY_LE_CRC32;
		quot   = variant_shadow[crc32wb_pkg::VAR_BIT_CASTAG] ? crc32wb_pkg::QT_LE_CRC32C
			: crc32wb_pkg::QT_LE_CRC32;
		// Counts above eight saturate; a zero count folds nothing.
		nbytes = (count > 4'd8) ? 4'd8 : count;
		crc    = first ? seed_shadow : prev;
		if (nbytes == 4'(crc32wb_pkg::WORD_BYTES)) begin
			crc = normal ? fold_word_normal(crc, data) : fold_word_reflected(crc, data, poly, quot);
		end else begin
			for (int i = 0; i < nbytes; i++) begin
				crc = normal ? fold_byte_normal(crc, data[8*i +: 8])
					: fold_byte_reflected(crc, data[8*i +: 8], poly);
			end
		end
		return crc;
	endfunction

	// ---------------------------------------------------------------------------------------
	// Sender. A transaction stays on the bus until it is taken; a new one is offered only
	// after that, unless a random gap holds it back. The prediction is made at acceptance,
	// from the bits that were actually on the bus.
	// ---------------------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				remainder_model = fold_item(remainder_model, s_axis_tdata[63:0],
					s_axis_tdata[67:64], s_axis_tuser);
				crc_expect_q.push_back(remainder_model);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_items.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 26)) begin
					next_item = pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {4'b0, next_item.count, next_item.data};
					s_axis_tuser  <= next_item.first;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// Receiver. Each accepted result is checked against the oldest expectation. Once in the
	// run the receiver refuses results for a long stretch so that the engine backs up and
	// stops taking input while the sender keeps offering.
	// ---------------------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (crc_expect_q.size() == 0) begin
					$error("crc_value: no result expected, actual %08h", m_axis_tdata);
					mismatches++;
				end else begin
					if (m_axis_tdata !== crc_expect_q[0]) begin
						$error("crc_value: expected %08h, actual %08h", crc_expect_q[0],
							m_axis_tdata);
						mismatches++;
					end
					void'(crc_expect_q.pop_front());
					outstanding--;
				end
			end
			if (hold_left != 0) begin
				hold_left     <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (results_seen >= HOLD_AT && !hold_done) begin
				hold_left     <= HOLD_CYCLES;
				hold_done     <= 1'b1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 26);
			end
		end
	end

	// Hang detection: the run ends when no transaction moves on either side for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// ---------------------------------------------------------------------------------------
	// Stimulus.
	// ---------------------------------------------------------------------------------------
	task automatic queue_item(logic first, logic [3:0] count, logic [63:0] data);
		crc_item_t it;
		it.first = first;
		it.count = count;
		it.data  = data;
		pending_items.push_back(it);
		outstanding++;
	endtask

	// Only called while the engine is idle: nothing pending and every result back.
	task automatic write_reg(logic idx, logic [31:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_wdata <= $urandom;
		if (idx == crc32wb_pkg::CFG_IDX_VARIANT)
			variant_shadow = value[crc32wb_pkg::VARIANT_W-1:0];
		else
			seed_shadow = value;
	endtask

	task automatic drain();
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Random message content. Most items are full words; short items, empty items and
	// oversized counts come less often, and the data has random bits above the count too.
	function automatic logic [3:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 4'd8;
		else if (r < 88)
			return 4'($urandom_range(1, 7));
		else if (r < 94)
			return 4'd0;
		else
			return 4'($urandom_range(9, 15));
	endfunction

	function automatic logic [63:0] pick_data();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		else if (r < 8)
			return '1;
		else
			return {$urandom, $urandom};
	endfunction

	initial begin
		int left;
		int msg_len;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset configuration: reflected CRC-32 with a zero seed.
		queue_item(1'b1, 4'd8, 64'h0);
		queue_item(1'b0, 4'd8, '1);
		queue_item(1'b0, 4'd0, {$urandom, $urandom});   // empty item keeps the remainder
		queue_item(1'b1, 4'd0, '1);                     // empty item reports the seed
		queue_item(1'b0, 4'd15, {$urandom, $urandom});  // oversized counts fold eight bytes
		queue_item(1'b0, 4'd9, {$urandom, $urandom});
		queue_item(1'b0, 4'd1, '1);                     // bytes past the count are ignored
		for (int n = 2; n < 8; n++)
			queue_item(1'b0, 4'(n), {$urandom, $urandom});
		drain();

		// Variant three, all-ones seed, with stray bits above the variant field.
		write_reg(crc32wb_pkg::CFG_IDX_VARIANT, {$urandom} | 32'h3);
		write_reg(crc32wb_pkg::CFG_IDX_SEED, 32'hffff_ffff);
		queue_item(1'b1, 4'd8, '1);
		queue_item(1'b0, 4'd8, 64'h0);
		queue_item(1'b0, 4'd3, '1);
		queue_item(1'b1, 4'd0, {$urandom, $urandom});
		queue_item(1'b0, 4'd12, {$urandom, $urandom});
		queue_item(1'b1, 4'd5, {$urandom, $urandom});
		drain();

		// Random phases: each one writes both registers, then streams messages that start
		// from the seed and continue over several items. Now and then a message starts
		// without the first flag or a first flag shows up in the middle of one.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_reg(crc32wb_pkg::CFG_IDX_VARIANT, ({$urandom} & ~32'h3) | 32'(p % 4));
			unique case (p)
				0, 7:    write_reg(crc32wb_pkg::CFG_IDX_SEED, 32'h0);
				1, 6:    write_reg(crc32wb_pkg::CFG_IDX_SEED, 32'hffff_ffff);
				default: write_reg(crc32wb_pkg::CFG_IDX_SEED, $urandom);
			endcase
			// One phase streams with no gaps on either side.
			gaps_on = (p != 3);
			left = PHASE_ITEMS;
			while (left > 0) begin
				msg_len = $urandom_range(1, 12);
				for (int k = 0; k < msg_len && left > 0; k++) begin
					if (k == 0)
						queue_item($urandom_range(0, 9) != 0, pick_count(), pick_data());
					else
						queue_item($urandom_range(0, 99) < 3, pick_count(), pick_data());
					left--;
				end
			end
			drain();
		end
		gaps_on = 1'b1;

		// Let any stray result show up before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (crc_expect_q.size() != 0) begin
			$error("crc_value: %0d expected results never arrived", crc_expect_q.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
